@@ rtl/page_span_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// page_span_allocator_assert.svh
// Assertion macros for the page span allocator.
// ----------------------------------------------------------------------------
`ifndef PAGE_SPAN_ALLOCATOR_ASSERT_SVH
`define PAGE_SPAN_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define PSA_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PSA_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PSA_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define PSA_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

@@ rtl/psa_pkg.sv @@
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types and constants of the page span allocator.
// ----------------------------------------------------------------------------
package psa_pkg;
	localparam int unsigned MaxSpanPages = 128;
	localparam int unsigned RecordSlots = 1024;
	localparam int unsigned PageShift = 12;
	localparam int unsigned PageW = 36;
	localparam int unsigned CountW = 8;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_REGION = 2'd2;
	localparam logic [1:0] ST_NOREC = 2'd3;

	localparam logic CFG_BASE = 1'b0;
	localparam logic CFG_END = 1'b1;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_SCAN,
		S_POP,
		S_READ,
		S_SPLIT,
		S_REFILL,
		S_APPEND,
		S_DONE
	} state_t;

	typedef struct packed {
		logic init_step;
		logic load;
		logic scan_step;
		logic pop;
		logic read_rec;
		logic split;
		logic refill;
		logic append;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic init_done;
		logic zero_req;
		logic found;
		logic scan_end;
		logic remainder;
		logic region_bad;
		logic spare_empty;
		logic need_rec;
	} sts_t;
endpackage

@@ rtl/psa_ctrl.sv @@
// ----------------------------------------------------------------------------
// psa_ctrl
// Sequencer for the page span allocator.
// ----------------------------------------------------------------------------
module psa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  psa_pkg::sts_t  sts,
	output logic           busy,
	output psa_pkg::cmd_t  cmd
);
	import psa_pkg::*;
	`include "page_span_allocator_assert.svh"

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_INIT;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			S_INIT: begin
				cmd.init_step = 1'b1;
				if (sts.init_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.zero_req) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end else if (sts.found) state_d = S_POP;
				else if (sts.scan_end) state_d = S_REFILL;
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_d = S_READ;
			end
			S_READ: begin
				cmd.read_rec = 1'b1;
				state_d = S_SPLIT;
			end
			S_SPLIT: begin
				cmd.split = 1'b1;
				state_d = sts.remainder ? S_APPEND : S_DONE;
			end
			S_REFILL: begin
				cmd.refill = 1'b1;
				if (sts.region_bad || (sts.need_rec && sts.spare_empty)) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end else state_d = sts.need_rec ? S_APPEND : S_DONE;
			end
			S_APPEND: begin
				cmd.append = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	`PSA_NEVER(a_idle_not_busy, clk, arst_n, (state_q == S_IDLE) && busy, "idle yet busy")
	`PSA_ASSERT_IMPL(a_start_loads, clk, arst_n, (start && !busy) |=> (state_q == S_SCAN), "request not taken")
	`PSA_NEVER(a_finish_idle, clk, arst_n, cmd.finish && (state_d != S_IDLE), "finish without idle")
endmodule

@@ rtl/psa_datapath.sv @@
// ----------------------------------------------------------------------------
// psa_datapath
// Class lists, span records and the fresh page pointer.
// ----------------------------------------------------------------------------
module psa_datapath #(
	parameter int unsigned MAX_SPAN_PAGES = psa_pkg::MaxSpanPages,
	parameter int unsigned RECORD_SLOTS = psa_pkg::RecordSlots
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  psa_pkg::cmd_t                cmd,
	output psa_pkg::sts_t                sts,
	input  logic [7:0]                   pages_wanted,
	input  logic                         cfg_valid,
	input  logic                         cfg_index,
	input  logic [psa_pkg::PageW-1:0]    cfg_data,
	output logic                         result_valid,
	output logic [psa_pkg::PageW-1:0]    span_start_page,
	output logic [7:0]                   span_pages,
	output logic [1:0]                   status
);
	import psa_pkg::*;
	`include "page_span_allocator_assert.svh"

	localparam int unsigned CW = $clog2(MAX_SPAN_PAGES);
	localparam int unsigned RW = $clog2(RECORD_SLOTS);
	localparam logic [7:0] MAXP = 8'(MAX_SPAN_PAGES);

	logic [PageW-1:0] base_q, end_q, fresh_q;
	logic [MAX_SPAN_PAGES-1:0] nonempty_q;
	logic [RW-1:0] head_mem [MAX_SPAN_PAGES];
	logic [RW-1:0] tail_mem [MAX_SPAN_PAGES];
	logic [PageW-1:0] start_mem [RECORD_SLOTS];
	logic [7:0] count_mem [RECORD_SLOTS];
	logic [RW:0] link_mem [RECORD_SLOTS];
	logic [RW:0] spare_q;
	logic [RW:0] init_q;

	logic [7:0] want_q;
	logic [CW:0] cls_q;
	logic [CW-1:0] acls_q;
	logic [RW-1:0] rec_q, head_q, tail_q;
	logic [PageW-1:0] rstart_q;
	logic [7:0] rcount_q;
	logic hit_q;

	// pointers
	logic [CW-1:0] cls_i;
	assign cls_i = cls_q[CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			end_q <= '1;
			fresh_q <= '0;
			nonempty_q <= '0;
			spare_q <= '0;
			init_q <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.finish;
			if (cmd.init_step) init_q <= init_q + 1'b1;
			if (cfg_valid) begin
				if (cfg_index == CFG_BASE) begin
					base_q <= cfg_data;
					fresh_q <= cfg_data;
				end else end_q <= cfg_data;
			end
			if (cmd.pop && (head_q == tail_q)) nonempty_q[cls_i] <= 1'b0;
			if (cmd.split && !(rcount_q > want_q)) spare_q <= {1'b0, rec_q};
			if (cmd.refill && !sts.region_bad && !(sts.need_rec && sts.spare_empty)) begin
				fresh_q <= fresh_q + PageW'(MAX_SPAN_PAGES);
				if (sts.need_rec) spare_q <= link_mem[spare_q[RW-1:0]];
			end
			if (cmd.append) nonempty_q[acls_q] <= 1'b1;
		end
	end

	// request, scan and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			want_q <= (pages_wanted > MAXP) ? MAXP : pages_wanted;
			cls_q <= (pages_wanted > MAXP) ? (CW+1)'(MAX_SPAN_PAGES - 1)
				: (CW+1)'(pages_wanted - 8'd1);
			hit_q <= 1'b0;
		end
		if (cmd.scan_step) begin
			if (nonempty_q[cls_i]) hit_q <= 1'b1;
			else cls_q <= cls_q + 1'b1;
			head_q <= head_mem[cls_i];
			tail_q <= tail_mem[cls_i];
		end
		if (cmd.pop) begin
			rec_q <= head_q;
		end
		if (cmd.read_rec) begin
			rstart_q <= start_mem[rec_q];
			rcount_q <= count_mem[rec_q];
		end
		if (cmd.refill) begin
			rec_q <= spare_q[RW-1:0];
			rstart_q <= fresh_q;
			rcount_q <= MAXP;
		end
		if (cmd.split || cmd.refill) begin
			acls_q <= CW'((cmd.refill ? MAXP : rcount_q) - want_q - 8'd1);
			tail_q <= tail_mem[CW'((cmd.refill ? MAXP : rcount_q) - want_q - 8'd1)];
		end
		if (cmd.split || cmd.refill) begin
			span_start_page <= cmd.refill ? fresh_q : rstart_q;
			span_pages <= want_q;
			status <= ST_OK;
		end
		if (cmd.scan_step && sts.zero_req) begin
			span_start_page <= '0;
			span_pages <= '0;
			status <= ST_ZERO;
		end
		if (cmd.refill && (sts.region_bad || (sts.need_rec && sts.spare_empty))) begin
			span_start_page <= '0;
			span_pages <= '0;
			status <= sts.region_bad ? ST_REGION : ST_NOREC;
		end
	end

	// head/tail lists
	always_ff @(posedge clk) begin
		if (cmd.pop && (head_q != tail_q)) head_mem[cls_i] <= link_mem[head_q][RW-1:0];
		if (cmd.append) begin
			tail_mem[acls_q] <= rec_q;
			if (!nonempty_q[acls_q]) head_mem[acls_q] <= rec_q;
		end
	end

	// records: one write port, sequenced so only one write per cycle
	always_ff @(posedge clk) begin
		if (cmd.init_step) link_mem[init_q[RW-1:0]] <= (RW+1)'(init_q + 1'b1);
		else if (cmd.split && !(rcount_q > want_q)) link_mem[rec_q] <= spare_q;
		else if (cmd.append && nonempty_q[acls_q]) link_mem[tail_q] <= {1'b0, rec_q};
		if (cmd.split && (rcount_q > want_q)) begin
			start_mem[rec_q] <= rstart_q + PageW'(want_q);
			count_mem[rec_q] <= rcount_q - want_q;
		end else if (cmd.refill && sts.need_rec && !sts.region_bad && !sts.spare_empty) begin
			start_mem[spare_q[RW-1:0]] <= fresh_q + PageW'(want_q);
			count_mem[spare_q[RW-1:0]] <= MAXP - want_q;
		end
	end

	logic [PageW:0] room;
	assign room = {1'b0, end_q} - {1'b0, fresh_q};

	always_comb begin
		sts = '0;
		sts.init_done = (init_q == (RW+1)'(RECORD_SLOTS - 1));
		sts.zero_req = (want_q == 8'd0);
		sts.found = nonempty_q[cls_i] && !hit_q;
		sts.scan_end = !nonempty_q[cls_i] && (cls_q == (CW+1)'(MAX_SPAN_PAGES - 1));
		sts.remainder = rcount_q > want_q;
		sts.region_bad = (fresh_q >= end_q) || (room < (PageW+1)'(MAX_SPAN_PAGES));
		sts.spare_empty = (spare_q == (RW+1)'(RECORD_SLOTS));
		sts.need_rec = want_q < MAXP;
	end

	`PSA_NEVER(a_spare_range, clk, arst_n, spare_q > (RW+1)'(RECORD_SLOTS), "spare head out of range")
	`PSA_ASSERT_IMPL(a_ok_pages, clk, arst_n, (result_valid && (status == ST_OK)) |-> (span_pages != 8'd0), "ok with no pages")
	`PSA_ASSERT_IMPL(a_err_zero, clk, arst_n, (result_valid && (status != ST_OK)) |-> (span_pages == 8'd0), "error with pages")
endmodule

@@ rtl/page_span_allocator.sv @@
// ----------------------------------------------------------------------------
// page_span_allocator
// Segregated free-list span allocator over page numbers.
// ----------------------------------------------------------------------------
// After reset the record link store is chained slot by slot, with busy high.
// A zero-page request goes from scan back to idle. A list hit runs scan, pop,
// read, split, append when a remainder is left, and done; a refill scans
// every class from the request's upward to MAX_SPAN_PAGES, then runs refill,
// append if a record is needed, and done, or ends early on an error. The
// scan checks one class per cycle; the record store has one write port. One
// result per request, on result_valid for one cycle; the receiver can't stall.
module page_span_allocator #(
	parameter int unsigned MAX_SPAN_PAGES = psa_pkg::MaxSpanPages,
	parameter int unsigned RECORD_SLOTS = psa_pkg::RecordSlots
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [7:0]                pages_wanted,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_index,
	input  logic [psa_pkg::PageW-1:0] cfg_data,
	output logic                      result_valid,
	output logic [psa_pkg::PageW-1:0] span_start_page,
	output logic [7:0]                span_pages,
	output logic [1:0]                status
);
	import psa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	psa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .busy(busy), .cmd(cmd)
	);

	psa_datapath #(.MAX_SPAN_PAGES(MAX_SPAN_PAGES), .RECORD_SLOTS(RECORD_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.pages_wanted(pages_wanted),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_valid(result_valid), .span_start_page(span_start_page),
		.span_pages(span_pages), .status(status)
	);
endmodule

@@ dv/tb_page_span_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_page_span_allocator
// Self-checking testbench for the page span allocator.
// ----------------------------------------------------------------------------
// Requests come from a queue filled phase by phase. Each accepted request is
// run through a local copy of the size-class lists, the spare record chain and
// the region pointer, and the granted span is compared with the strobed
// result. The region registers are changed between phases, with the block idle.
// Phases cover the directed corners, a region too small to refill, the top of
// the page space, and running the record store dry. Random traffic follows.
// ----------------------------------------------------------------------------
module tb_page_span_allocator;
	import psa_pkg::*;

	localparam int unsigned CycleLimit = 4000000;
	localparam int unsigned SettleCycles = 200;
	localparam logic [35:0] AllOnes = 36'hF_FFFF_FFFF;

	typedef struct {
		logic [35:0] start_page;
		logic [7:0]  pages;
		logic [1:0]  st;
	} grant_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [7:0]  pages_wanted = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_BASE;
	logic [35:0] cfg_data = '0;
	logic        result_valid;
	logic [35:0] span_start_page;
	logic [7:0]  span_pages;
	logic [1:0]  status;

	// allocator mirror
	logic [35:0] base_page, end_page, fresh_page;
	logic        cls_full [MaxSpanPages];
	int unsigned cls_head [MaxSpanPages];
	int unsigned cls_tail [MaxSpanPages];
	logic [35:0] rec_start [RecordSlots];
	int unsigned rec_count [RecordSlots];
	int unsigned rec_link [RecordSlots];
	int unsigned spare_head;

	logic [7:0]  request_q [$];
	grant_t      grant_q [$];
	int unsigned gap_left = 0;
	bit          gaps_on = 1'b1;
	int unsigned errors = 0;
	int unsigned cycles = 0;

	page_span_allocator uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pages_wanted(pages_wanted), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .result_valid(result_valid),
		.span_start_page(span_start_page), .span_pages(span_pages), .status(status)
	);

	always #10 clk = ~clk;

	function automatic void class_push(int unsigned cls, int unsigned r);
		if (cls_full[cls]) begin
			rec_link[cls_tail[cls]] = r;
			cls_tail[cls] = r;
		end else begin
			cls_head[cls] = r;
			cls_tail[cls] = r;
			cls_full[cls] = 1'b1;
		end
	endfunction

	function automatic grant_t grant_span(logic [7:0] req);
		grant_t g;
		int unsigned want, r;
		logic [35:0] s;
		g.start_page = '0;
		g.pages = '0;
		g.st = ST_ZERO;
		if (req == 0)
			return g;
		want = (req > MaxSpanPages) ? MaxSpanPages : 32'(req);
		for (int unsigned c = want - 1; c < MaxSpanPages; c++) begin
			if (cls_full[c]) begin
				r = cls_head[c];
				if (cls_head[c] == cls_tail[c])
					cls_full[c] = 1'b0;
				else
					cls_head[c] = rec_link[r];
				s = rec_start[r];
				if (rec_count[r] > want) begin
					rec_start[r] = s + want;
					rec_count[r] -= want;
					class_push(rec_count[r] - 1, r);
				end else begin
					rec_link[r] = spare_head;
					spare_head = r;
				end
				g.start_page = s;
				g.pages = 8'(want);
				g.st = ST_OK;
				return g;
			end
		end
		if (fresh_page >= end_page || end_page - fresh_page < MaxSpanPages) begin
			g.st = ST_REGION;
			return g;
		end
		if (want < MaxSpanPages) begin
			if (spare_head >= RecordSlots) begin
				g.st = ST_NOREC;
				return g;
			end
			r = spare_head;
			spare_head = rec_link[r];
			rec_start[r] = fresh_page + want;
			rec_count[r] = MaxSpanPages - want;
			class_push(rec_count[r] - 1, r);
		end
		g.start_page = fresh_page;
		g.pages = 8'(want);
		g.st = ST_OK;
		fresh_page = fresh_page + MaxSpanPages;
		return g;
	endfunction

	function automatic int unsigned draw_gap();
		int unsigned p;
		p = $urandom_range(99);
		if (!gaps_on || p < 55)
			return 0;
		if (p < 92)
			return $urandom_range(3, 1);
		return $urandom_range(60, 8);
	endfunction

	function automatic logic [7:0] draw_pages();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 6)
			return 8'd0;
		if (p < 18)
			return 8'($urandom_range(255, 129));
		if (p < 60)
			return 8'($urandom_range(8, 1));
		if (p < 70)
			return 8'(MaxSpanPages);
		return 8'($urandom_range(MaxSpanPages, 1));
	endfunction

	// request driver
	always @(posedge clk) begin
		if (start && !busy)
			grant_q.push_back(grant_span(pages_wanted));
		if (start && busy) begin
			// hold the current request
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			start <= 1'b0;
		end else if (request_q.size() > 0) begin
			start <= 1'b1;
			pages_wanted <= request_q.pop_front();
			gap_left <= draw_gap();
		end else begin
			start <= 1'b0;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (result_valid) begin
			if (grant_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result start=%h pages=%0d status=%0d",
					$time, span_start_page, span_pages, status);
			end else begin
				grant_t g;
				g = grant_q.pop_front();
				if (span_start_page !== g.start_page || span_pages !== g.pages ||
					status !== g.st) begin
					errors++;
					$display("%0t: mismatch exp start=%h pages=%0d status=%0d got start=%h pages=%0d status=%0d",
						$time, g.start_page, g.pages, g.st,
						span_start_page, span_pages, status);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("FAIL page_span_allocator");
			$finish;
		end
	end

	task automatic drain();
		while (request_q.size() > 0 || start || grant_q.size() > 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [35:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_BASE) begin
			base_page = value;
			fresh_page = value;
		end else begin
			end_page = value;
		end
		@(posedge clk);
	endtask

	task automatic set_region(logic [35:0] b, logic [35:0] e);
		drain();
		write_reg(CFG_BASE, b);
		write_reg(CFG_END, e);
	endtask

	task automatic random_requests(int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			request_q.push_back(draw_pages());
	endtask

	initial begin
		logic [35:0] b;
		base_page = '0;
		end_page = AllOnes;
		fresh_page = '0;
		spare_head = 0;
		for (int i = 0; i < MaxSpanPages; i++) begin
			cls_full[i] = 1'b0;
			cls_head[i] = 0;
			cls_tail[i] = 0;
		end
		for (int i = 0; i < RecordSlots; i++) begin
			rec_start[i] = '0;
			rec_count[i] = 0;
			rec_link[i] = i + 1;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed corners at reset region
		request_q.push_back(8'd0); request_q.push_back(8'd255);
		request_q.push_back(8'd128); request_q.push_back(8'd1);
		request_q.push_back(8'd127); request_q.push_back(8'd1);
		request_q.push_back(8'd2); request_q.push_back(8'd64);
		request_q.push_back(8'd129); request_q.push_back(8'd3);
		request_q.push_back(8'd61); request_q.push_back(8'd85);
		request_q.push_back(8'd170); request_q.push_back(8'd0);
		request_q.push_back(8'd126); request_q.push_back(8'd2);

		// top of page space: one refill fits, the next does not
		set_region(AllOnes - 36'd129, AllOnes);
		request_q.push_back(8'd5); request_q.push_back(8'd200);
		request_q.push_back(8'd128); request_q.push_back(8'd100);
		request_q.push_back(8'd1);
		// empty and too-small regions
		set_region('0, '0);
		request_q.push_back(8'd1); request_q.push_back(8'd128);
		request_q.push_back(8'd40);
		set_region(36'h123, 36'h123 + 36'd127);
		request_q.push_back(8'd128); request_q.push_back(8'd7);

		// run the record store dry with one-page fragments
		set_region(36'h100, AllOnes);
		gaps_on = 1'b0;
		for (int i = 0; i < RecordSlots + 8; i++)
			request_q.push_back(8'd127);
		gaps_on = 1'b1;
		random_requests(200);

		for (int ph = 0; ph < 5; ph++) begin
			b = {4'($urandom_range(15)), $urandom()};
			if ($urandom_range(1))
				set_region(b, AllOnes);
			else
				set_region(b & 36'h0_FFFF_FFFF, (b & 36'h0_FFFF_FFFF) +
					$urandom_range(40, 1) * MaxSpanPages + $urandom_range(127));
			gaps_on = (ph != 2);
			random_requests(150);
		end
		drain();

		if (errors == 0)
			$display("PASS page_span_allocator");
		else
			$display("FAIL page_span_allocator");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/psa_pkg.sv
rtl/psa_ctrl.sv
rtl/psa_datapath.sv
rtl/page_span_allocator.sv
dv/tb_page_span_allocator.sv
